[hdl/sscc_pkg.sv]
package sscc_pkg;

   // Sizes
   localparam int MAX_CHANNELS   = 4;
   localparam int MASK_FRAC_BITS = 12;
   localparam int ACC_WIDTH      = 48;

   localparam int BYTE_W  = 8;
   localparam int MASK_W  = 16;
   localparam int SUM_W   = BYTE_W + $clog2(MAX_CHANNELS + 1);
   localparam int DIFF_W  = SUM_W + 1;
   localparam int WGT_W   = (MASK_W + 1 > MASK_FRAC_BITS + 2) ? MASK_W + 1 : MASK_FRAC_BITS + 2;
   localparam int PROD_W  = DIFF_W + WGT_W;

   // Chip generator
   localparam logic [31:0] LCG_MUL = 32'd1664525;
   localparam logic [31:0] LCG_INC = 32'd1013904223;

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEED          = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHIP_LENGTH   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPEAT_COUNT  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL_COUNT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_USE_MASK      = 3'd4;

   // Input word
   typedef struct packed {
      logic              start_req;
      logic [BYTE_W-1:0] pixel_a_ch0;
      logic [BYTE_W-1:0] pixel_a_ch1;
      logic [BYTE_W-1:0] pixel_a_ch2;
      logic [BYTE_W-1:0] pixel_a_ch3;
      logic [BYTE_W-1:0] pixel_b_ch0;
      logic [BYTE_W-1:0] pixel_b_ch1;
      logic [BYTE_W-1:0] pixel_b_ch2;
      logic [BYTE_W-1:0] pixel_b_ch3;
      logic [MASK_W-1:0] mask_a;
      logic [MASK_W-1:0] mask_b;
   } req_type;

   // Result word
   typedef struct packed {
      logic       data_bit;
      logic [7:0] ones_votes;
   } rsp_type;

endpackage

[hdl/spread_spectrum_chip_correlator_top.sv]
// A vote's last sample is held in the input register, then its result in the result register.
// Throughput: one sample per cycle while result words are taken; the accumulate/decide
// logic between the input register and the result register is combinational.
// While a result word waits, the input register still takes one sample and then holds it.
// Reset: synchronous, active high; registers take their defaults and the generator clears to 0.
module spread_spectrum_chip_correlator_top
   import sscc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [31:0] seed_ff;
   logic [15:0] chip_length_ff;
   logic [7:0]  repeat_count_ff;
   logic [2:0]  channel_count_ff;
   logic        use_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff          <= '0;
         chip_length_ff   <= 16'd256;
         repeat_count_ff  <= 8'd1;
         channel_count_ff <= 3'd3;
         use_mask_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SEED:          seed_ff          <= csr_wdata[31:0];
            CSR_CHIP_LENGTH:   chip_length_ff   <= csr_wdata[15:0];
            CSR_REPEAT_COUNT:  repeat_count_ff  <= csr_wdata[7:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[2:0];
            CSR_USE_MASK:      use_mask_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Handshake
   logic    s1_vld_ff;
   req_type s1_data_ff;
   logic    s1_chip_ff;
   logic    rsp_vld_ff;
   rsp_type rsp_data_ff;
   logic    s1_adv;
   logic    req_acc;

   assign s1_adv    = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // Chip generator, stepped as each word is taken
   logic [31:0] lcg_ff;
   logic [31:0] lcg_in;

   always_comb begin
      lcg_in = (req_data.start_req ? seed_ff : lcg_ff) * LCG_MUL + LCG_INC;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         if (req_acc) lcg_ff <= lcg_in;
         if (req_acc) s1_vld_ff <= 1'b1;
         else if (s1_adv) s1_vld_ff <= 1'b0;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_data_ff <= req_data;
         s1_chip_ff <= lcg_in[31];
      end
   end

   // Correlation state
   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic [15:0] sidx_ff, sidx_in;
   logic [7:0]  ridx_ff, ridx_in;
   logic [7:0]  tally_ff, tally_in;
   logic        emit;
   rsp_type     rsp_in;

   // Accumulate and decide
   logic [BYTE_W-1:0] ch_a [4];
   logic [BYTE_W-1:0] ch_b [4];
   logic [2:0]        nch;
   logic [SUM_W-1:0]  sum_a, sum_b;
   logic signed [DIFF_W-1:0] diff;
   logic [WGT_W-1:0]  weight;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_WIDTH-1:0] acc_cur, acc_sat;
   logic signed [ACC_WIDTH:0]   acc_sum;
   logic [15:0] sidx_cur, len;
   logic [7:0]  ridx_cur, tally_cur, tally_new, rep;

   always_comb begin
      ch_a[0] = s1_data_ff.pixel_a_ch0;
      ch_a[1] = s1_data_ff.pixel_a_ch1;
      ch_a[2] = s1_data_ff.pixel_a_ch2;
      ch_a[3] = s1_data_ff.pixel_a_ch3;
      ch_b[0] = s1_data_ff.pixel_b_ch0;
      ch_b[1] = s1_data_ff.pixel_b_ch1;
      ch_b[2] = s1_data_ff.pixel_b_ch2;
      ch_b[3] = s1_data_ff.pixel_b_ch3;

      // clamp channel count into 1..MAX_CHANNELS
      if (channel_count_ff == 3'd0) nch = 3'd1;
      else if (channel_count_ff > 3'(MAX_CHANNELS)) nch = 3'(MAX_CHANNELS);
      else nch = channel_count_ff;

      sum_a = '0;
      sum_b = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (3'(c) < nch) begin
            sum_a = sum_a + SUM_W'(ch_a[c]);
            sum_b = sum_b + SUM_W'(ch_b[c]);
         end
      end
      diff = $signed({1'b0, sum_a}) - $signed({1'b0, sum_b});

      if (use_mask_ff)
         weight = WGT_W'(s1_data_ff.mask_a) + WGT_W'(s1_data_ff.mask_b);
      else
         weight = WGT_W'(2) << MASK_FRAC_BITS;

      prod = PROD_W'(diff * $signed({1'b0, weight}));
      if (!s1_chip_ff) prod = -prod;

      // start clears the counters before this sample
      acc_cur   = s1_data_ff.start_req ? '0 : acc_ff;
      sidx_cur  = s1_data_ff.start_req ? '0 : sidx_ff;
      ridx_cur  = s1_data_ff.start_req ? '0 : ridx_ff;
      tally_cur = s1_data_ff.start_req ? '0 : tally_ff;

      // saturating add
      acc_sum = {acc_cur[ACC_WIDTH-1], acc_cur} + (ACC_WIDTH+1)'(prod);
      if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1])
         acc_sat = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                      : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      else
         acc_sat = acc_sum[ACC_WIDTH-1:0];

      len = (chip_length_ff == 16'd0) ? 16'd1 : chip_length_ff;
      rep = (repeat_count_ff == 8'd0) ? 8'd1 : repeat_count_ff;

      tally_new = tally_cur + 8'(!acc_sat[ACC_WIDTH-1] && (|acc_sat));
      emit      = 1'b0;
      rsp_in.data_bit   = ({1'b0, tally_new, 1'b0} > {2'b00, rep});
      rsp_in.ones_votes = tally_new;

      if ({1'b0, sidx_cur} + 17'd1 < {1'b0, len}) begin
         acc_in   = acc_sat;
         sidx_in  = sidx_cur + 16'd1;
         ridx_in  = ridx_cur;
         tally_in = tally_cur;
      end else begin
         acc_in  = '0;
         sidx_in = '0;
         if ({1'b0, ridx_cur} + 9'd1 < {1'b0, rep}) begin
            ridx_in  = ridx_cur + 8'd1;
            tally_in = tally_new;
         end else begin
            ridx_in  = '0;
            tally_in = '0;
            emit     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         sidx_ff  <= '0;
         ridx_ff  <= '0;
         tally_ff <= '0;
      end else if (s1_adv) begin
         acc_ff   <= acc_in;
         sidx_ff  <= sidx_in;
         ridx_ff  <= ridx_in;
         tally_ff <= tally_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         if (rsp_ready) rsp_vld_ff <= 1'b0;
         if (s1_adv && emit) rsp_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && emit) rsp_data_ff <= rsp_in;
   end

   // Checks
   a_acc_clear_at_bit_start: assert property (@(posedge clock) disable iff (reset)
      (sidx_ff == 16'd0) |-> (acc_ff == '0))
      else $error("accumulator not cleared at raw bit start");

   a_tally_bounded: assert property (@(posedge clock) disable iff (reset)
      tally_ff <= ridx_ff)
      else $error("ones tally exceeds raw bits decided");

   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ready) |=> (rsp_vld_ff && $stable(rsp_data_ff)))
      else $error("pending result lost or overwritten");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_vld_ff && rsp_vld_ff))
      else $error("input stalled without a full pipeline");

endmodule

[dv/vote_checker.sv]
`timescale 1ns / 1ps

// Watches the sample, result and register ports of the correlator, keeps its
// own copy of the chip generator and vote counters, and compares every result
// word against the oldest predicted vote.
module vote_checker
   import sscc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           mismatch_count,
   output int unsigned           votes_pending
);

   // Shadow registers
   logic [31:0] cfg_seed;
   logic [15:0] cfg_chip_length;
   logic [7:0]  cfg_repeat;
   logic [2:0]  cfg_channels;
   logic        cfg_use_mask;

   // Predicted datapath state
   logic [31:0] chip_lcg;
   longint      corr_sum;
   logic [15:0] sample_idx;
   logic [7:0]  raw_idx;
   logic [7:0]  ones_tally;

   rsp_type     votes_q[$];
   rsp_type     new_vote;
   rsp_type     expected_vote;

   // One chip sample through the despreader; returns 1 when a vote completes
   function automatic bit despread_sample(input req_type w, output rsp_type vote);
      logic [15:0] len;
      logic [7:0]  rep;
      int          nch;
      longint      sum_a;
      longint      sum_b;
      longint      weight;
      longint      prod;
      longint      acc_hi;
      longint      acc_lo;

      len = (cfg_chip_length == 0) ? 16'd1 : cfg_chip_length;
      rep = (cfg_repeat == 0) ? 8'd1 : cfg_repeat;
      nch = (cfg_channels == 0) ? 1 : int'(cfg_channels);
      if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
      vote = '0;

      if (w.start_req) begin
         chip_lcg   = cfg_seed;
         corr_sum   = 0;
         sample_idx = '0;
         raw_idx    = '0;
         ones_tally = '0;
      end

      chip_lcg = chip_lcg * LCG_MUL + LCG_INC;

      // channel sums over the active channels only
      sum_a = w.pixel_a_ch0;
      sum_b = w.pixel_b_ch0;
      if (nch > 1) begin sum_a += w.pixel_a_ch1; sum_b += w.pixel_b_ch1; end
      if (nch > 2) begin sum_a += w.pixel_a_ch2; sum_b += w.pixel_b_ch2; end
      if (nch > 3) begin sum_a += w.pixel_a_ch3; sum_b += w.pixel_b_ch3; end

      if (cfg_use_mask) begin
         weight = w.mask_a;
         weight += w.mask_b;
      end else begin
         weight = longint'(2) << MASK_FRAC_BITS;
      end

      prod = (sum_a - sum_b) * weight;
      if (!chip_lcg[31]) prod = -prod;

      // saturating accumulate at the signed accumulator width
      acc_hi = (longint'(1) << (ACC_WIDTH - 1)) - 1;
      acc_lo = -acc_hi - 1;
      if (prod > 0 && corr_sum > acc_hi - prod) corr_sum = acc_hi;
      else if (prod < 0 && corr_sum < acc_lo - prod) corr_sum = acc_lo;
      else corr_sum += prod;

      if (sample_idx + 1 < len) begin
         sample_idx = sample_idx + 16'd1;
         return 1'b0;
      end

      // raw bit decided
      if (corr_sum > 0) ones_tally = ones_tally + 8'd1;
      corr_sum   = 0;
      sample_idx = '0;

      if (raw_idx + 1 < rep) begin
         raw_idx = raw_idx + 8'd1;
         return 1'b0;
      end

      // vote complete
      vote.data_bit   = (ones_tally * 2 > rep);
      vote.ones_votes = ones_tally;
      raw_idx    = '0;
      ones_tally = '0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_seed        = '0;
         cfg_chip_length = 16'd256;
         cfg_repeat      = 8'd1;
         cfg_channels    = 3'd3;
         cfg_use_mask    = 1'b0;
         chip_lcg        = '0;
         corr_sum        = 0;
         sample_idx      = '0;
         raw_idx         = '0;
         ones_tally      = '0;
         mismatch_count  = 0;
         votes_q.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               CSR_SEED:          cfg_seed        = csr_wdata;
               CSR_CHIP_LENGTH:   cfg_chip_length = csr_wdata[15:0];
               CSR_REPEAT_COUNT:  cfg_repeat      = csr_wdata[7:0];
               CSR_CHANNEL_COUNT: cfg_channels    = csr_wdata[2:0];
               CSR_USE_MASK:      cfg_use_mask    = csr_wdata[0];
               default: ;
            endcase
         end

         // accepted sample word
         if (req_valid && req_ready) begin
            if (despread_sample(req_data, new_vote)) votes_q.push_back(new_vote);
         end

         // accepted result word
         if (rsp_valid && rsp_ready) begin
            if (votes_q.size() == 0) begin
               $error("ones_votes: expected no word, actual %0d", rsp_data.ones_votes);
               mismatch_count = mismatch_count + 1;
            end else begin
               expected_vote = votes_q.pop_front();
               if (rsp_data.data_bit !== expected_vote.data_bit) begin
                  $error("data_bit: expected %0d, actual %0d",
                         expected_vote.data_bit, rsp_data.data_bit);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_data.ones_votes !== expected_vote.ones_votes) begin
                  $error("ones_votes: expected %0d, actual %0d",
                         expected_vote.ones_votes, rsp_data.ones_votes);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
      end
      votes_pending = votes_q.size();
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import sscc_pkg::*;

   localparam int ITEM_TARGET = 850;
   localparam int IDLE_LIMIT  = 2000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned votes_pending;
   int unsigned samples_sent  = 0;
   int unsigned gap_max       = 4;
   int unsigned rsp_stall_max = 4;
   int unsigned rsp_draw;
   int unsigned rsp_hold      = 0;
   int unsigned idle_cycles   = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   spread_spectrum_chip_correlator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   vote_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .votes_pending  (votes_pending)
   );

   // Result side: random stall after each accepted word
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_draw = $urandom_range(0, rsp_stall_max);
         rsp_hold  <= rsp_draw;
         rsp_ready <= (rsp_draw == 0);
      end else if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_mask();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic req_type uniform_word(input logic start, input logic [7:0] a,
                                            input logic [7:0] b, input logic [15:0] ma,
                                            input logic [15:0] mb);
      req_type w;
      w.start_req   = start;
      w.pixel_a_ch0 = a;
      w.pixel_a_ch1 = a;
      w.pixel_a_ch2 = a;
      w.pixel_a_ch3 = a;
      w.pixel_b_ch0 = b;
      w.pixel_b_ch1 = b;
      w.pixel_b_ch2 = b;
      w.pixel_b_ch3 = b;
      w.mask_a      = ma;
      w.mask_b      = mb;
      return w;
   endfunction

   function automatic req_type random_word(input logic start);
      req_type w;
      w.start_req   = start;
      w.pixel_a_ch0 = pick_byte();
      w.pixel_a_ch1 = pick_byte();
      w.pixel_a_ch2 = pick_byte();
      w.pixel_a_ch3 = pick_byte();
      w.pixel_b_ch0 = pick_byte();
      w.pixel_b_ch1 = pick_byte();
      w.pixel_b_ch2 = pick_byte();
      w.pixel_b_ch3 = pick_byte();
      w.mask_a      = pick_mask();
      w.mask_b      = pick_mask();
      return w;
   endfunction

   // Valid stays up across back-to-back words; it only drops for a gap or a drain
   task automatic send_word(input req_type w);
      int unsigned gap;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] seed_val, input logic [15:0] chip_len,
                             input logic [7:0] rep, input logic [2:0] nch,
                             input logic mask_on);
      write_reg(CSR_SEED, seed_val);
      write_reg(CSR_CHIP_LENGTH, 32'(chip_len));
      write_reg(CSR_REPEAT_COUNT, 32'(rep));
      write_reg(CSR_CHANNEL_COUNT, 32'(nch));
      write_reg(CSR_USE_MASK, 32'(mask_on));
      csr_we <= 1'b0;
   endtask

   // Wait for every predicted vote, then let a partial bit settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (votes_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      req_type     w;
      int unsigned phase;
      int unsigned count;
      logic [31:0] seed_val;
      logic [15:0] chip_len;
      logic [7:0]  rep;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // One vote per sample, generator never seeded
      set_config(32'h0, 16'd1, 8'd1, 3'd3, 1'b0);
      send_word(uniform_word(1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000));
      send_word(uniform_word(1'b0, 8'hFF, 8'h00, 16'hFFFF, 16'hFFFF));
      send_word(uniform_word(1'b0, 8'h00, 8'hFF, 16'hFFFF, 16'h0000));
      send_word(random_word(1'b0));
      drain();

      // Mask weighting, channel count zero acts as one
      set_config(32'hFFFF_FFFF, 16'd1, 8'd1, 3'd0, 1'b1);
      send_word(uniform_word(1'b1, 8'hFF, 8'h00, 16'hFFFF, 16'hFFFF));
      send_word(uniform_word(1'b0, 8'hFF, 8'h00, 16'h0000, 16'h0000));
      send_word(uniform_word(1'b0, 8'h00, 8'hFF, 16'h0001, 16'h0000));
      drain();

      // Channel count above the maximum clamps to four
      set_config($urandom(), 16'd1, 8'd1, 3'd7, 1'b1);
      w = uniform_word(1'b1, 8'h10, 8'h10, 16'h1000, 16'h1000);
      w.pixel_a_ch3 = 8'hFF;
      send_word(w);
      w.start_req   = 1'b0;
      w.pixel_b_ch3 = 8'hFF;
      w.pixel_b_ch2 = 8'h00;
      send_word(w);
      drain();

      set_config($urandom(), 16'd1, 8'd1, 3'd4, 1'b0);
      send_word(w);
      drain();
      set_config($urandom(), 16'd1, 8'd1, 3'd5, 1'b0);
      send_word(w);
      drain();

      // Zero chip length and zero repeat count act as one
      set_config($urandom(), 16'd0, 8'd0, 3'd4, 1'b0);
      send_word(random_word(1'b1));
      send_word(random_word(1'b0));
      send_word(random_word(1'b0));
      drain();

      // Two raw bits of three samples, then a bit cut short by a lower chip length
      seed_val = $urandom();
      set_config(seed_val, 16'd3, 8'd2, 3'd2, 1'b0);
      send_word(random_word(1'b1));
      repeat (7) send_word(random_word(1'b0));
      drain();
      set_config(seed_val, 16'd1, 8'd1, 3'd2, 1'b0);
      send_word(random_word(1'b0));
      drain();

      // Random phases, each mostly a well-formed stream opened by a start
      phase = 0;
      while (samples_sent < ITEM_TARGET) begin
         phase++;
         gap_max       = ($urandom_range(0, 3) == 0) ? 0 : 4;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 4;

         case ($urandom_range(0, 9))
            0:       seed_val = 32'h0;
            1:       seed_val = 32'hFFFF_FFFF;
            default: seed_val = $urandom();
         endcase
         case ($urandom_range(0, 9))
            0:       chip_len = 16'd0;
            1:       chip_len = 16'($urandom_range(7, 40));
            default: chip_len = 16'($urandom_range(1, 6));
         endcase
         rep   = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 7));
         count = $urandom_range(10, 60);

         // one long vote and one partial bit at the longest chip length
         if (phase == 2) begin
            chip_len = 16'd1;
            rep      = 8'd255;
            count    = 300;
         end else if (phase == 4) begin
            chip_len = 16'hFFFF;
            rep      = 8'd1;
            count    = 40;
         end

         set_config(seed_val, chip_len, rep, 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)));
         send_word(random_word($urandom_range(0, 7) != 0));
         repeat (count - 1) send_word(random_word($urandom_range(0, 39) == 0));
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

[sim.f]
hdl/sscc_pkg.sv
hdl/spread_spectrum_chip_correlator_top.sv
dv/vote_checker.sv
dv/tb_top.sv
